// ===== rtl/sscp_pkg.sv =====
// Shared types and constants for the shadow slot cache policy block.
package sscp_pkg;

    localparam int SLOTS_DEF = 8;

    localparam int POS_W     = 32;
    localparam int ID_W      = 16;
    localparam int FRAME_W   = 32;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;
    localparam int IN_W      = 160;
    localparam int OUT_W     = 24;
    localparam int OPND_W    = 34;

    localparam logic [CFG_W-1:0] TOL_RESET = 16'd66;
    localparam logic [CFG_W-1:0] AGE_RESET = 16'd100;

    localparam logic [CFG_IDX_W-1:0] REG_TOL = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AGE = 1'd1;

    localparam logic FUNC_LOOKUP = 1'b0;
    localparam logic FUNC_SWEEP  = 1'b1;

    localparam logic [1:0] AXIS_X    = 2'd0;
    localparam logic [1:0] AXIS_Y    = 2'd1;
    localparam logic [1:0] AXIS_LAST = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_AXIS,
        S_SWEEP,
        S_DONE
    } state_t;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic [ID_W-1:0]         owner;
        logic [ID_W-1:0]         caster;
    } key_t;

    typedef struct packed {
        logic near;
        logic less;
    } cmp_res_t;

endpackage

// ===== rtl/sscp_cmp_unit.sv =====
// Shared subtract and compare unit: tolerance match and signed less-than.
module sscp_cmp_unit (
    input  logic signed [sscp_pkg::OPND_W-1:0] a,
    input  logic signed [sscp_pkg::OPND_W-1:0] b,
    input  logic [sscp_pkg::CFG_W-1:0]         tol,
    output sscp_pkg::cmp_res_t                 res
);
    import sscp_pkg::*;

    logic signed [OPND_W:0] diff;
    logic [OPND_W:0]        mag;

    always_comb
    begin
        diff = {a[OPND_W-1], a} - {b[OPND_W-1], b};
        mag  = diff[OPND_W] ? (OPND_W+1)'(-diff) : diff;
        res.near = (mag <= {{(OPND_W+1-CFG_W){1'b0}}, tol});
        res.less = diff[OPND_W];
    end

endmodule

// ===== rtl/shadow_slot_cache_policy.sv =====
// Top level: slot table, scan sequencer and result register.
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  tdata: light_x,y,z, owner, caster, frame; tuser: func
//  m_*       out  m_tvalid/m_tready  tdata: slot_index, hit, rebuild, alloc, evicted, count
//  cfg_*     in   cfg_we             cfg_index, cfg_data
//
// A lookup passes through S_LOAD, S_AXIS and S_DONE before m_tvalid rises: one compare
// unit checks one position axis of one slot per cycle, fed by one memory read port.
// A sweep passes through S_LOAD, S_SWEEP and S_DONE, one slot per cycle through the same unit.
// One item at a time; s_tready is high only while idle, so a new item is taken only once
// the previous result has been handed to the output register.
// A finished result waits in the output register; a stall holds the sequencer
// in its last state. Reset clears the valid bits and count and loads the register defaults.
module shadow_slot_cache_policy #(
    parameter int SLOTS = sscp_pkg::SLOTS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [31:0] light_x, [63:32] light_y, [95:64] light_z, [111:96] light_owner,
    // [127:112] caster_id, [159:128] frame_number
    input  logic [sscp_pkg::IN_W-1:0]       s_tdata,
    // [0] func
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [2:0] slot_index, [3] exact_hit, [4] needs_rebuild, [5] newly_allocated,
    // [13:6] evicted_mask, [17:14] allocated_count, [23:18] zero
    output logic [sscp_pkg::OUT_W-1:0]      m_tdata,
    input  logic                            cfg_we,
    input  logic [sscp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sscp_pkg::CFG_W-1:0]      cfg_data
);
    import sscp_pkg::*;

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [IW-1:0] IDX_LAST = IW'(SLOTS - 1);

    state_t state_reg, state_next;

    logic [CFG_W-1:0] tol_reg, age_reg;

    logic             req_func_reg;
    key_t             req_key_reg;
    logic [FRAME_W-1:0] req_frame_reg;

    logic [IW-1:0]    idx_reg;
    logic [1:0]       axis_reg;
    logic             near_acc_reg;

    logic [SLOTS-1:0] valid_reg;
    logic [CW-1:0]    cnt_reg;

    key_t             key_mem [SLOTS];
    logic [FRAME_W-1:0] frame_mem [SLOTS];
    key_t             rd_key_reg;
    logic [FRAME_W-1:0] rd_frame_reg;

    logic             hit_found_reg, reuse_found_reg, free_found_reg, oldest_set_reg;
    logic [IW-1:0]    hit_idx_reg, reuse_idx_reg, free_idx_reg, oldest_idx_reg;
    logic [FRAME_W-1:0] oldest_frame_reg;
    logic [7:0]       mask_reg;

    logic             m_tvalid_reg;
    logic [2:0]       out_slot_reg;
    logic             out_hit_reg, out_rebuild_reg, out_alloc_reg;
    logic [7:0]       out_mask_reg;
    logic [3:0]       out_cnt_reg;

    logic             rd_en;
    logic [IW-1:0]    rd_addr;
    logic             done_fire;

    logic signed [OPND_W-1:0] opnd_a, opnd_b;
    logic signed [POS_W-1:0]  stored_axis, req_axis;
    cmp_res_t                 cmp;

    logic             near_all;
    logic             reuse_cond;
    logic             older;
    logic [IW-1:0]    choice_idx;
    logic             alloc;
    logic [CW-1:0]    cnt_after;
    logic [IW+2:0]    choice_ext;
    logic [IW+2:0]    scan_ext;
    logic [CW+3:0]    cnt_ext;

    sscp_cmp_unit u_cmp (
        .a   (opnd_a),
        .b   (opnd_b),
        .tol (tol_reg),
        .res (cmp)
    );

    // Operand select for the shared compare unit
    always_comb
    begin
        case (axis_reg)
            AXIS_X:
            begin
                stored_axis = rd_key_reg.pos_x;
                req_axis    = req_key_reg.pos_x;
            end
            AXIS_Y:
            begin
                stored_axis = rd_key_reg.pos_y;
                req_axis    = req_key_reg.pos_y;
            end
            default:
            begin
                stored_axis = rd_key_reg.pos_z;
                req_axis    = req_key_reg.pos_z;
            end
        endcase
        if (state_reg == S_SWEEP)
        begin
            opnd_a = {2'b00, rd_frame_reg} + {{(OPND_W-CFG_W){1'b0}}, age_reg};
            opnd_b = {2'b00, req_frame_reg};
        end
        else
        begin
            opnd_a = {{(OPND_W-POS_W){stored_axis[POS_W-1]}}, stored_axis};
            opnd_b = {{(OPND_W-POS_W){req_axis[POS_W-1]}}, req_axis};
        end
    end

    always_comb
    begin
        near_all   = near_acc_reg & cmp.near;
        reuse_cond = valid_reg[idx_reg] &&
                     (rd_key_reg.owner == req_key_reg.owner) &&
                     (rd_key_reg.caster == req_key_reg.caster) &&
                     (({1'b0, rd_frame_reg} + 33'd1) < {1'b0, req_frame_reg});
        older      = rd_frame_reg < oldest_frame_reg;

        if (hit_found_reg)
            choice_idx = hit_idx_reg;
        else if (reuse_found_reg)
            choice_idx = reuse_idx_reg;
        else if (free_found_reg)
            choice_idx = free_idx_reg;
        else
            choice_idx = oldest_idx_reg;

        alloc      = (req_func_reg == FUNC_LOOKUP) && !hit_found_reg &&
                     !valid_reg[choice_idx];
        cnt_after  = cnt_reg + CW'(alloc);
        choice_ext = {3'b000, choice_idx};
        scan_ext   = {3'b000, idx_reg};
        cnt_ext    = {4'b0000, cnt_after};
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (s_tvalid)
                    state_next = S_LOAD;
            S_LOAD:
                state_next = (req_func_reg == FUNC_SWEEP) ? S_SWEEP : S_AXIS;
            S_AXIS:
                if (axis_reg == AXIS_LAST && idx_reg == IDX_LAST)
                    state_next = S_DONE;
            S_SWEEP:
                if (idx_reg == IDX_LAST)
                    state_next = S_DONE;
            S_DONE:
                if (done_fire)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        s_tready  = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = idx_reg + IW'(1);
        done_fire = 1'b0;
        case (state_reg)
            S_IDLE:
                s_tready = 1'b1;
            S_LOAD:
            begin
                rd_en   = 1'b1;
                rd_addr = '0;
            end
            S_AXIS:
                rd_en = (axis_reg == AXIS_LAST) && (idx_reg != IDX_LAST);
            S_SWEEP:
                rd_en = (idx_reg != IDX_LAST);
            S_DONE:
                done_fire = !m_tvalid_reg || m_tready;
            default:
                s_tready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= TOL_RESET;
            age_reg <= AGE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TOL: tol_reg <= cfg_data;
                REG_AGE: age_reg <= cfg_data;
                default: tol_reg <= tol_reg;
            endcase
        end
    end

    // Request capture
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            req_func_reg       <= s_tuser;
            req_key_reg.pos_x  <= s_tdata[31:0];
            req_key_reg.pos_y  <= s_tdata[63:32];
            req_key_reg.pos_z  <= s_tdata[95:64];
            req_key_reg.owner  <= s_tdata[111:96];
            req_key_reg.caster <= s_tdata[127:112];
            req_frame_reg      <= s_tdata[159:128];
        end
    end

    // Slot memories
    always_ff @(posedge clk)
    begin
        if (done_fire && req_func_reg == FUNC_LOOKUP)
        begin
            frame_mem[choice_idx] <= req_frame_reg;
            if (!hit_found_reg)
                key_mem[choice_idx] <= req_key_reg;
        end
        if (rd_en)
        begin
            rd_key_reg   <= key_mem[rd_addr];
            rd_frame_reg <= frame_mem[rd_addr];
        end
    end

    // Scan state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg         <= '0;
            axis_reg        <= AXIS_X;
            near_acc_reg    <= 1'b0;
            hit_found_reg   <= 1'b0;
            reuse_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            oldest_set_reg  <= 1'b0;
            mask_reg        <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    idx_reg         <= '0;
                    axis_reg        <= AXIS_X;
                    hit_found_reg   <= 1'b0;
                    reuse_found_reg <= 1'b0;
                    free_found_reg  <= 1'b0;
                    oldest_set_reg  <= 1'b0;
                    mask_reg        <= '0;
                end
                S_AXIS:
                begin
                    if (axis_reg == AXIS_X)
                        near_acc_reg <= cmp.near;
                    else
                        near_acc_reg <= near_all;
                    if (axis_reg == AXIS_LAST)
                    begin
                        axis_reg <= AXIS_X;
                        if (idx_reg != IDX_LAST)
                            idx_reg <= idx_reg + IW'(1);
                        if (valid_reg[idx_reg] && near_all && !hit_found_reg)
                        begin
                            hit_found_reg <= 1'b1;
                            hit_idx_reg   <= idx_reg;
                        end
                        if (reuse_cond && !reuse_found_reg)
                        begin
                            reuse_found_reg <= 1'b1;
                            reuse_idx_reg   <= idx_reg;
                        end
                        if (!valid_reg[idx_reg] && !free_found_reg)
                        begin
                            free_found_reg <= 1'b1;
                            free_idx_reg   <= idx_reg;
                        end
                        if (valid_reg[idx_reg] && (!oldest_set_reg || older))
                        begin
                            oldest_set_reg   <= 1'b1;
                            oldest_idx_reg   <= idx_reg;
                            oldest_frame_reg <= rd_frame_reg;
                        end
                    end
                    else
                        axis_reg <= axis_reg + 2'd1;
                end
                S_SWEEP:
                begin
                    if (idx_reg != IDX_LAST)
                        idx_reg <= idx_reg + IW'(1);
                    if (valid_reg[idx_reg] && cmp.less && scan_ext < (IW+3)'(8))
                        mask_reg[scan_ext[2:0]] <= 1'b1;
                end
                default:
                    idx_reg <= idx_reg;
            endcase
        end
    end

    // Valid bits and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            cnt_reg   <= '0;
        end
        else if (state_reg == S_SWEEP)
        begin
            if (valid_reg[idx_reg] && cmp.less)
            begin
                valid_reg[idx_reg] <= 1'b0;
                cnt_reg            <= cnt_reg - CW'(1);
            end
        end
        else if (done_fire && req_func_reg == FUNC_LOOKUP)
        begin
            valid_reg[choice_idx] <= 1'b1;
            cnt_reg               <= cnt_after;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (done_fire)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (done_fire)
        begin
            if (req_func_reg == FUNC_LOOKUP)
            begin
                out_slot_reg    <= choice_ext[2:0];
                out_hit_reg     <= hit_found_reg;
                out_rebuild_reg <= !hit_found_reg;
                out_alloc_reg   <= alloc;
                out_mask_reg    <= '0;
                out_cnt_reg     <= cnt_ext[3:0];
            end
            else
            begin
                out_slot_reg    <= '0;
                out_hit_reg     <= 1'b0;
                out_rebuild_reg <= 1'b0;
                out_alloc_reg   <= 1'b0;
                out_mask_reg    <= mask_reg;
                out_cnt_reg     <= cnt_ext[3:0];
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b000000, out_cnt_reg, out_mask_reg, out_alloc_reg,
                       out_rebuild_reg, out_hit_reg, out_slot_reg};

    a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cnt_reg) == $countones(valid_reg))
        else $error("slot count differs from valid bits");

    a_hit_no_rebuild: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg |-> !(out_hit_reg && out_rebuild_reg))
        else $error("hit reported together with rebuild");

    a_alloc_needs_rebuild: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && out_alloc_reg) |-> out_rebuild_reg)
        else $error("allocation without rebuild");

    a_lookup_marks_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (done_fire && req_func_reg == FUNC_LOOKUP) |=> valid_reg[$past(choice_idx)])
        else $error("chosen slot not valid after lookup");

endmodule

// ===== tb/sscp_tb_pkg.sv =====
`timescale 1ns / 1ps
// Scoreboard for the shadow slot cache policy: slot table predictor and reply checker.
package sscp_tb_pkg;
    import sscp_pkg::*;

    localparam int TABLE_SLOTS = 8;

    typedef struct packed {
        logic [2:0] slot;
        logic       hit;
        logic       rebuild;
        logic       alloc;
        logic [7:0] freed;
        logic [3:0] live_count;
    } slot_reply_t;

    class slot_cache_scoreboard;
        logic               used [TABLE_SLOTS];
        logic [31:0]        stamp [TABLE_SLOTS];
        logic signed [31:0] spot [TABLE_SLOTS][3];
        logic [15:0]        owner_id [TABLE_SLOTS];
        logic [15:0]        caster_id [TABLE_SLOTS];
        int                 live;
        logic [15:0]        tol;
        logic [15:0]        age;
        int                 errors;
        slot_reply_t        awaited[$];

        function new();
            for (int i = 0; i < TABLE_SLOTS; i++)
            begin
                used[i]      = 1'b0;
                stamp[i]     = '0;
                spot[i][0]   = '0;
                spot[i][1]   = '0;
                spot[i][2]   = '0;
                owner_id[i]  = '0;
                caster_id[i] = '0;
            end
            live   = 0;
            tol    = TOL_RESET;
            age    = AGE_RESET;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
            if (idx == REG_TOL)
                tol = value;
            else
                age = value;
        endfunction

        function bit close(logic signed [31:0] a, logic signed [31:0] b);
            longint d;
            d = longint'(a) - longint'(b);
            if (d < 0)
                d = -d;
            return d <= longint'(tol);
        endfunction

        // Work out the reply for one accepted request and queue it.
        function void take_request(logic func, logic signed [31:0] px,
                                   logic signed [31:0] py, logic signed [31:0] pz,
                                   logic [15:0] own, logic [15:0] cst, logic [31:0] frm);
            slot_reply_t r;
            int          found;
            int          oldest;
            int          i;
            r = '0;
            if (func == FUNC_SWEEP)
            begin
                for (i = 0; i < TABLE_SLOTS; i++)
                begin
                    if (used[i] && (64'(stamp[i]) + 64'(age) < 64'(frm)))
                    begin
                        used[i]  = 1'b0;
                        stamp[i] = '0;
                        if (live > 0)
                            live--;
                        r.freed[i] = 1'b1;
                    end
                end
            end
            else
            begin
                found = -1;
                for (i = 0; i < TABLE_SLOTS; i++)
                begin
                    if (found < 0 && used[i] && close(spot[i][0], px) &&
                        close(spot[i][1], py) && close(spot[i][2], pz))
                        found = i;
                end
                if (found >= 0)
                begin
                    stamp[found] = frm;
                    r.hit = 1'b1;
                end
                else
                begin
                    // same light and caster, idle for more than one frame
                    for (i = 0; i < TABLE_SLOTS; i++)
                    begin
                        if (found < 0 && used[i] && owner_id[i] == own &&
                            caster_id[i] == cst && (64'(stamp[i]) + 64'd1 < 64'(frm)))
                            found = i;
                    end
                    if (found < 0)
                    begin
                        oldest = 0;
                        for (i = 0; i < TABLE_SLOTS; i++)
                        begin
                            if (found < 0)
                            begin
                                if (!used[i])
                                    found = i;
                                else if (stamp[i] < stamp[oldest])
                                    oldest = i;
                            end
                        end
                        if (found < 0)
                            found = oldest;
                    end
                    if (!used[found])
                    begin
                        r.alloc     = 1'b1;
                        used[found] = 1'b1;
                        live++;
                    end
                    stamp[found]     = frm;
                    spot[found][0]   = px;
                    spot[found][1]   = py;
                    spot[found][2]   = pz;
                    owner_id[found]  = own;
                    caster_id[found] = cst;
                    r.rebuild = 1'b1;
                end
                r.slot = found[2:0];
            end
            r.live_count = live[3:0];
            awaited.push_back(r);
        endfunction

        function void compare(string field, int want, int got);
            if (want != got)
            begin
                errors++;
                $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
            end
        endfunction

        function void check_reply(logic [OUT_W-1:0] beat);
            slot_reply_t want;
            if (awaited.size() == 0)
            begin
                errors++;
                $display("%0t: reply %h with no request pending (expected none)", $time, beat);
                return;
            end
            want = awaited.pop_front();
            compare("slot_index", want.slot, beat[2:0]);
            compare("exact_hit", want.hit, beat[3]);
            compare("needs_rebuild", want.rebuild, beat[4]);
            compare("newly_allocated", want.alloc, beat[5]);
            compare("evicted_mask", want.freed, beat[13:6]);
            compare("allocated_count", want.live_count, beat[17:14]);
            compare("padding", 0, beat[23:18]);
        endfunction
    endclass

endpackage

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Testbench top: drives lookups, sweeps and register writes into the slot cache policy.
module tb;
    import sscp_pkg::*;
    import sscp_tb_pkg::*;

    localparam int PERIOD    = 10;
    localparam int RUN_LIMIT = 200000;
    localparam int DRAIN     = 3 * TABLE_SLOTS + 13;
    localparam int POOL      = 12;
    localparam int PHASES    = 6;
    localparam int PER_PHASE = 115;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [IN_W-1:0]      s_tdata = '0;
    logic                 s_tuser = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [OUT_W-1:0]     m_tdata;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    slot_cache_scoreboard sb;
    bit                   steady = 1'b0;
    int                   cur_tol = TOL_RESET;
    int                   cur_age = AGE_RESET;
    logic [31:0]          frame_now = '0;
    logic [31:0]          key_pos [POOL][3];
    logic [15:0]          key_own [POOL];
    logic [15:0]          key_cst [POOL];
    int                   cycles = 0;

    shadow_slot_cache_policy #(
        .SLOTS(TABLE_SLOTS)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #(PERIOD / 2) clk = ~clk;

    task automatic send_item(input logic func, input logic [31:0] px, input logic [31:0] py,
                             input logic [31:0] pz, input logic [15:0] own,
                             input logic [15:0] cst, input logic [31:0] frm);
        int gap;
        bit after_ready;
        gap = steady ? 0 : $urandom_range(0, 10);
        after_ready = $urandom_range(0, 1);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            // optionally start the gap only once the block is idle
            if (after_ready)
            begin
                do @(posedge clk); while (s_tready !== 1'b1);
            end
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {frm, cst, own, pz, py, px};
        s_tuser  <= func;
        do @(posedge clk); while (s_tready !== 1'b1);
        sb.take_request(func, px, py, pz, own, cst, frm);
    endtask

    // Drop valid and wait until every reply is back.
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.awaited.size() != 0)
            @(posedge clk);
    endtask

    function automatic void set_key(input int k);
        for (int a = 0; a < 3; a++)
            key_pos[k][a] = $urandom_range(0, 1) ? $urandom :
                            $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
        key_own[k] = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
        key_cst[k] = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2));
    endfunction

    // Move a coordinate onto, just inside or just past the match window.
    function automatic logic [31:0] nudge(input logic [31:0] base);
        case ($urandom_range(0, 7))
            0: return base + cur_tol;
            1: return base - cur_tol;
            2: return base + cur_tol + 1;
            3: return base - cur_tol - 1;
            4: return base + $urandom_range(0, 2 * cur_tol) - cur_tol;
            default: return base;
        endcase
    endfunction

    task automatic run_random(input int n);
        int pick;
        int k;
        for (int j = 0; j < n; j++)
        begin
            if (j % 40 == 0)
                steady = ($urandom_range(0, 3) == 0);
            frame_now += $urandom_range(0, 2);
            pick = $urandom_range(0, 99);
            k = $urandom_range(0, POOL - 1);
            if ($urandom_range(0, 19) == 0)
                set_key(k);
            if (pick < 55)
                send_item(FUNC_LOOKUP, nudge(key_pos[k][0]), nudge(key_pos[k][1]),
                          nudge(key_pos[k][2]), key_own[k], key_cst[k], frame_now);
            else if (pick < 75)
                send_item(FUNC_LOOKUP, $urandom, $urandom, $urandom,
                          key_own[k], key_cst[k], frame_now);
            else if (pick < 87)
            begin
                // jump ahead now and then so the sweep finds stale slots
                if ($urandom_range(0, 2) == 0)
                    frame_now += $urandom_range(0, 2 * cur_age + 2);
                send_item(FUNC_SWEEP, $urandom, $urandom, $urandom,
                          16'($urandom), 16'($urandom), frame_now);
            end
            else
                send_item(FUNC_LOOKUP, $urandom, $urandom, $urandom, 16'($urandom),
                          16'($urandom), $urandom_range(0, 1) ? $urandom : frame_now);
        end
    endtask

    initial
    begin
        int ph_tol [PHASES];
        int ph_age [PHASES];
        ph_tol = '{0, 65535, $urandom_range(0, 65535), TOL_RESET,
                   $urandom_range(0, 300), $urandom_range(0, 65535)};
        ph_age = '{1, 65535, 0, AGE_RESET,
                   $urandom_range(1, 200), $urandom_range(0, 65535)};
        sb = new();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // fill, hit at the window edge, reuse by identity, evict the oldest
        send_item(FUNC_LOOKUP, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 16'hFFFF, 16'h0, 32'd0);
        send_item(FUNC_LOOKUP, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 16'hFFFF, 16'h0, 32'd1);
        send_item(FUNC_LOOKUP, 32'h8000_0042, 32'h7FFF_FFFF, 32'h0, 16'hFFFF, 16'h0, 32'd2);
        send_item(FUNC_LOOKUP, 32'h8000_0000, 32'h7FFF_FFBC, 32'h0, 16'hFFFF, 16'h0, 32'd3);
        send_item(FUNC_LOOKUP, 32'h0, 32'h0, 32'h7FFF_FFFF, 16'hFFFF, 16'h0, 32'd10);
        send_item(FUNC_LOOKUP, 32'h0001_0000, 32'hFFFF_0000, 32'h1234_5678, 16'h0, 16'hFFFF,
                  32'hFFFF_FFFF);
        send_item(FUNC_LOOKUP, 32'h0002_0000, 32'hFFFE_0000, 32'h1234_5678, 16'h0, 16'hFFFF,
                  32'hFFFF_FFFF);
        for (int i = 0; i < 4; i++)
            send_item(FUNC_LOOKUP, 32'h0030_0000 + (i << 20), 32'hFFD0_0000 - (i << 20),
                      32'h5555_AAAA, 16'h5A5A ^ 16'(i), 16'hA5A5, 32'd20 + i);
        send_item(FUNC_LOOKUP, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 16'h1234, 16'h4321,
                  32'd5);
        send_item(FUNC_SWEEP, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 32'd50);
        send_item(FUNC_SWEEP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
                  32'd0);
        send_item(FUNC_SWEEP, $urandom, $urandom, $urandom, 16'($urandom), 16'($urandom),
                  32'd200);
        send_item(FUNC_LOOKUP, 32'h0100_0000, 32'h0200_0000, 32'h0300_0000, 16'h7, 16'h8,
                  32'd201);
        send_item(FUNC_LOOKUP, 32'h0100_0000 - 66, 32'h0200_0000 + 66, 32'h0300_0000, 16'h7,
                  16'h8, 32'd202);
        send_item(FUNC_SWEEP, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 32'hFFFF_FFFF);
        send_item(FUNC_LOOKUP, 32'h0001_0000, 32'hFFFF_0000, 32'h1234_5678, 16'h0, 16'hFFFF,
                  32'd300);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            settle();
            cur_tol = ph_tol[ph];
            cur_age = ph_age[ph];
            @(negedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= REG_TOL;
            cfg_data  <= CFG_W'(cur_tol);
            sb.write_reg(REG_TOL, CFG_W'(cur_tol));
            @(negedge clk);
            cfg_index <= REG_AGE;
            cfg_data  <= CFG_W'(cur_age);
            sb.write_reg(REG_AGE, CFG_W'(cur_age));
            @(negedge clk);
            cfg_we <= 1'b0;
            for (int k = 0; k < POOL; k++)
                set_key(k);
            frame_now = (ph == 1) ? 32'hFFFF_FE00 : 32'($urandom_range(0, 1000));
            run_random(PER_PHASE);
        end

        settle();
        repeat (DRAIN) @(posedge clk);
        if (sb.errors == 0 && sb.awaited.size() == 0)
            $display("shadow_slot_cache_policy: match");
        else
            $display("shadow_slot_cache_policy: mismatch");
        $finish;
    end

    // Reply side: stall either from the last beat or from the moment a reply shows up.
    initial
    begin
        int gap;
        bit after_valid;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = steady ? 0 : $urandom_range(0, 10);
            after_valid = $urandom_range(0, 1);
            @(negedge clk);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                if (after_valid)
                begin
                    do @(posedge clk); while (m_tvalid !== 1'b1);
                end
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (m_tvalid !== 1'b1);
            sb.check_reply(m_tdata);
        end
    end

    initial
    begin
        while (cycles < RUN_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("shadow_slot_cache_policy: mismatch");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/sscp_pkg.sv
rtl/sscp_cmp_unit.sv
rtl/shadow_slot_cache_policy.sv
tb/sscp_tb_pkg.sv
tb/tb.sv
